[rtl/svbd_pkg.sv]
// shared types, constants and length decode for the stream vbyte delta decoder
package svbd_pkg;

  localparam int unsigned VAL_W   = 32;
  localparam int unsigned LANES   = 4;
  localparam int unsigned WIN_W   = 128;
  localparam int unsigned USED_W  = 5;
  localparam int unsigned OFS_W   = 4;
  localparam int unsigned LEN_W   = 3;
  localparam int unsigned CFG_A_W = 2;

  // byte lengths in the 0,1,2,4 mode, indexed by code
  localparam logic [3:0][LEN_W-1:0] LEN_ALT = {3'd4, 3'd2, 3'd1, 3'd0};

  typedef enum logic [CFG_A_W-1:0] {
    CFG_LENGTH_MODE   = 2'd0,
    CFG_ZIGZAG_ENABLE = 2'd1,
    CFG_START_VALUE   = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0]  key_byte;
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic        first_quad;
    logic        last_quad;
  } in_t;

  typedef struct packed {
    logic [VAL_W-1:0]  value_a;
    logic [VAL_W-1:0]  value_b;
    logic [VAL_W-1:0]  value_c;
    logic [VAL_W-1:0]  value_d;
    logic [USED_W-1:0] bytes_used;
    logic              last_out;
  } out_t;

  // decoded quad handed from the lanes to the merge stage
  typedef struct packed {
    logic [LANES-1:0][VAL_W-1:0] delta;
    logic [USED_W-1:0]           bytes_used;
    logic                        first;
    logic                        last;
  } quad_t;

  function automatic logic [LEN_W-1:0] code_len(input logic [1:0] code, input logic mode);
    logic [LEN_W-1:0] len;
    if (mode) begin
      len = LEN_ALT[code];
    end else begin
      len = {1'b0, code} + 3'd1;
    end
    return len;
  endfunction

endpackage

[rtl/stream_vbyte_delta_decoder_core.sv]
// top level: config registers, four decode lanes, lane register and merge stage
// One quad is taken every cycle while the output side keeps up. A result passes through
// the lane register, the partial sums and the output register before it is presented on
// the output. Sustained rate is one quad per cycle, set by the single 32-bit add that
// carries the running value from one quad to the next in the merge stage.
// Each lane decodes one integer from the 16-byte window at an offset computed
// from the key; first_quad reloads the running value from start_value.
module stream_vbyte_delta_decoder_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  svbd_pkg::in_t                in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output svbd_pkg::out_t               out_data,
  input  logic                         cfg_we,
  input  logic [svbd_pkg::CFG_A_W-1:0] cfg_index,
  input  logic [svbd_pkg::VAL_W-1:0]   cfg_wdata
);

  logic                       length_mode_r;
  logic                       zigzag_r;
  logic [svbd_pkg::VAL_W-1:0] start_value_r;

  logic [svbd_pkg::WIN_W-1:0]                      window;
  logic [svbd_pkg::LANES-1:0][svbd_pkg::LEN_W-1:0] len;
  logic [svbd_pkg::LANES-1:0][svbd_pkg::OFS_W-1:0] ofs;
  logic [svbd_pkg::USED_W-1:0]                     used;
  svbd_pkg::quad_t                                 quad_nxt;
  svbd_pkg::quad_t                                 quad_r;
  logic                                            s1_valid_r;
  logic                                            quad_ready;
  logic                                            ready1;
  logic                                            in_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_mode_r <= 1'b0;
      zigzag_r      <= 1'b0;
      start_value_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        svbd_pkg::CFG_LENGTH_MODE:   length_mode_r <= cfg_wdata[0];
        svbd_pkg::CFG_ZIGZAG_ENABLE: zigzag_r      <= cfg_wdata[0];
        svbd_pkg::CFG_START_VALUE:   start_value_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign window = {in_data.window_high, in_data.window_low};

  always_comb begin
    for (int k = 0; k < svbd_pkg::LANES; k++) begin
      len[k] = svbd_pkg::code_len(in_data.key_byte[2*k +: 2], length_mode_r);
    end
    // lane offsets are the running byte count of earlier lanes
    ofs[0] = '0;
    ofs[1] = {1'b0, len[0]};
    ofs[2] = ofs[1] + {1'b0, len[1]};
    ofs[3] = ofs[2] + {1'b0, len[2]};
    used   = {1'b0, ofs[3]} + {2'b00, len[3]};
  end

  for (genvar g = 0; g < svbd_pkg::LANES; g++) begin : g_lane
    svbd_lane u_lane (
      .window (window),
      .offset (ofs[g]),
      .len    (len[g]),
      .zigzag (zigzag_r),
      .delta  (quad_nxt.delta[g])
    );
  end

  assign quad_nxt.bytes_used = used;
  assign quad_nxt.first      = in_data.first_quad;
  assign quad_nxt.last       = in_data.last_quad;

  assign ready1   = !s1_valid_r || quad_ready;
  assign in_stall = !ready1;
  assign in_take  = in_valid && ready1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (ready1) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      quad_r <= quad_nxt;
    end
  end

  svbd_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .quad_valid  (s1_valid_r),
    .quad        (quad_r),
    .quad_ready  (quad_ready),
    .start_value (start_value_r),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && !quad_ready)
    else $error("input stalled with free lane register");

endmodule

[rtl/svbd_lane.sv]
// one decode lane: little-endian byte extract at an offset plus optional zigzag undo
module svbd_lane (
  input  logic [svbd_pkg::WIN_W-1:0] window,
  input  logic [svbd_pkg::OFS_W-1:0] offset,
  input  logic [svbd_pkg::LEN_W-1:0] len,
  input  logic                       zigzag,
  output logic [svbd_pkg::VAL_W-1:0] delta
);

  logic [svbd_pkg::WIN_W-1:0] shifted;
  logic [svbd_pkg::VAL_W-1:0] mask;
  logic [svbd_pkg::VAL_W-1:0] raw;

  assign shifted = window >> {offset, 3'b000};

  always_comb begin
    unique case (len)
      3'd0:    mask = 32'h0000_0000;
      3'd1:    mask = 32'h0000_00FF;
      3'd2:    mask = 32'h0000_FFFF;
      3'd3:    mask = 32'h00FF_FFFF;
      default: mask = 32'hFFFF_FFFF;
    endcase
  end

  assign raw = shifted[svbd_pkg::VAL_W-1:0] & mask;

  // zigzag undo: shift out the sign bit and flip all bits when it was set
  assign delta = zigzag ? ((raw >> 1) ^ {svbd_pkg::VAL_W{raw[0]}}) : raw;

endmodule

[rtl/svbd_merge.sv]
// merge stage: in-quad partial sums, then running prefix add and output register
module svbd_merge (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       quad_valid,
  input  svbd_pkg::quad_t            quad,
  output logic                       quad_ready,
  input  logic [svbd_pkg::VAL_W-1:0] start_value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output svbd_pkg::out_t             out_data
);

  logic                                          p_valid_r;
  logic [svbd_pkg::LANES-1:0][svbd_pkg::VAL_W-1:0] p_r;
  logic [svbd_pkg::LANES-1:0][svbd_pkg::VAL_W-1:0] p_nxt;
  logic [svbd_pkg::USED_W-1:0]                   used_r;
  logic                                          first_r;
  logic                                          last_r;

  logic                       out_valid_r;
  svbd_pkg::out_t             out_r;
  logic [svbd_pkg::VAL_W-1:0] run_r;
  logic [svbd_pkg::VAL_W-1:0] base;
  logic [svbd_pkg::VAL_W-1:0] run_nxt;

  logic ready2;
  logic ready3;
  logic load2;
  logic load3;

  assign ready3     = !out_valid_r || !out_stall;
  assign ready2     = !p_valid_r || ready3;
  assign quad_ready = ready2;
  assign load2      = quad_valid && ready2;
  assign load3      = p_valid_r && ready3;

  always_comb begin
    p_nxt[0] = quad.delta[0];
    p_nxt[1] = quad.delta[0] + quad.delta[1];
    p_nxt[2] = p_nxt[1] + quad.delta[2];
    p_nxt[3] = p_nxt[1] + (quad.delta[2] + quad.delta[3]);
  end

  // the only loop-carried path: one 32-bit add on the running value
  assign base    = first_r ? start_value : run_r;
  assign run_nxt = base + p_r[3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      run_r       <= '0;
    end else begin
      if (ready2) begin
        p_valid_r <= quad_valid;
      end
      if (ready3) begin
        out_valid_r <= p_valid_r;
      end
      if (load3) begin
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      p_r     <= p_nxt;
      used_r  <= quad.bytes_used;
      first_r <= quad.first;
      last_r  <= quad.last;
    end
    if (load3) begin
      out_r.value_a    <= base + p_r[0];
      out_r.value_b    <= base + p_r[1];
      out_r.value_c    <= base + p_r[2];
      out_r.value_d    <= run_nxt;
      out_r.bytes_used <= used_r;
      out_r.last_out   <= last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_run_tracks_out: assert property (@(posedge clk) disable iff (!rst_n)
    load3 |=> run_r == out_r.value_d)
    else $error("running value differs from last delivered value");

  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_r.bytes_used <= 5'd16)
    else $error("bytes_used above sixteen");

  a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r && !ready3 |=> p_valid_r && $stable(p_r))
    else $error("partial sums lost while output stalled");

endmodule

[bench/stream_vbyte_delta_decoder_core_chk.sv]
// checker for the stream vbyte delta decoder: predicts each quad and compares results
`timescale 1ns / 100ps

module stream_vbyte_delta_decoder_core_chk
  import svbd_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  in_t                in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  out_t               out_data,
  input  logic               cfg_we,
  input  logic [CFG_A_W-1:0] cfg_index,
  input  logic [VAL_W-1:0]   cfg_wdata,
  output int                 fail_count,
  output int                 pending
);

  logic             mode_reg;
  logic             zz_reg;
  logic [VAL_W-1:0] start_reg;
  logic [VAL_W-1:0] run_value;
  out_t             expected_quads[$];
  int               errors;

  initial begin
    fail_count = 0;
    pending = 0;
    errors = 0;
    mode_reg = 1'b0;
    zz_reg = 1'b0;
    start_reg = '0;
    run_value = '0;
  end

  // decode one quad against the current register copy, advancing the running sum
  function automatic out_t decode_quad(input in_t q);
    logic [127:0]          win;
    logic [VAL_W-1:0]      acc;
    logic [VAL_W-1:0]      v;
    logic [1:0]            code;
    int unsigned           len;
    int unsigned           pos;
    logic [3:0][VAL_W-1:0] sums;
    out_t                  r;
    win = {q.window_high, q.window_low};
    if (q.first_quad) begin
      run_value = start_reg;
    end
    acc = run_value;
    pos = 0;
    for (int k = 0; k < 4; k++) begin
      code = q.key_byte[2*k +: 2];
      if (mode_reg) begin
        len = (code == 2'd3) ? 4 : code;
      end else begin
        len = code + 1;
      end
      v = '0;
      for (int b = 0; b < len; b++) begin
        v[8*b +: 8] = win[8*(pos+b) +: 8];
      end
      pos += len;
      if (zz_reg) begin
        v = {1'b0, v[VAL_W-1:1]} ^ {VAL_W{v[0]}};
      end
      acc += v;
      sums[k] = acc;
    end
    run_value = acc;
    r.value_a = sums[0];
    r.value_b = sums[1];
    r.value_c = sums[2];
    r.value_d = sums[3];
    r.bytes_used = pos[USED_W-1:0];
    r.last_out = q.last_quad;
    return r;
  endfunction

  task automatic check_field(input string name, input logic [VAL_W-1:0] exp_v,
                             input logic [VAL_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s: expected %h, got %h", name, exp_v, got_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      mode_reg = 1'b0;
      zz_reg = 1'b0;
      start_reg = '0;
      run_value = '0;
      expected_quads.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_LENGTH_MODE:   mode_reg = cfg_wdata[0];
          CFG_ZIGZAG_ENABLE: zz_reg = cfg_wdata[0];
          CFG_START_VALUE:   start_reg = cfg_wdata;
          default: ;
        endcase
      end
      // compare before pushing so a stray result never pairs with a fresh quad
      if (out_valid && !out_stall) begin
        if (expected_quads.size() == 0) begin
          $error("out_data: transfer with no expected result, got %h", out_data);
          errors++;
        end else begin
          want = expected_quads.pop_front();
          check_field("value_a", want.value_a, out_data.value_a);
          check_field("value_b", want.value_b, out_data.value_b);
          check_field("value_c", want.value_c, out_data.value_c);
          check_field("value_d", want.value_d, out_data.value_d);
          check_field("bytes_used", VAL_W'(want.bytes_used), VAL_W'(out_data.bytes_used));
          check_field("last_out", VAL_W'(want.last_out), VAL_W'(out_data.last_out));
        end
      end
      if (in_valid && !in_stall) begin
        expected_quads.push_back(decode_quad(in_data));
      end
    end
    pending <= expected_quads.size();
    fail_count <= errors;
  end

endmodule

[bench/stream_vbyte_delta_decoder_core_tb.sv]
// testbench top: clock, reset, quad stimulus, register phases and the verdict
`timescale 1ns / 100ps

module stream_vbyte_delta_decoder_core_tb;
  import svbd_pkg::*;

  localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASES = 10;
  localparam int PHASE_QUADS = 155;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_we = 1'b0;
  logic [CFG_A_W-1:0] cfg_index = CFG_LENGTH_MODE;
  logic [VAL_W-1:0]   cfg_wdata = '0;

  int   fail_count;
  int   pending;
  logic idle_on = 1'b0;
  int   cycles = 0;
  int   stall_left = 0;

  stream_vbyte_delta_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  stream_vbyte_delta_decoder_core_chk chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("stream_vbyte_delta_decoder_core regression: fail");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 18) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic in_t make_quad(input logic [7:0] key, input logic [63:0] lo,
                                    input logic [63:0] hi, input logic first,
                                    input logic last);
    in_t q;
    q.key_byte = key;
    q.window_low = lo;
    q.window_high = hi;
    q.first_quad = first;
    q.last_quad = last;
    return q;
  endfunction

  // holds the quad until the transfer; an optional gap goes in front
  task automatic send_quad(input in_t q);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= q;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic program_regs(input logic [VAL_W-1:0] mode_w, input logic [VAL_W-1:0] zz_w,
                              input logic [VAL_W-1:0] start_w, input logic poke_unused);
    cfg_we <= 1'b1;
    cfg_index <= CFG_LENGTH_MODE;
    cfg_wdata <= mode_w;
    @(posedge clk);
    cfg_index <= CFG_ZIGZAG_ENABLE;
    cfg_wdata <= zz_w;
    @(posedge clk);
    cfg_index <= CFG_START_VALUE;
    cfg_wdata <= start_w;
    @(posedge clk);
    if (poke_unused) begin
      cfg_index <= CFG_UNUSED;
      cfg_wdata <= $urandom;
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [63:0] pick_window();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  initial begin
    in_t              q;
    int               sent;
    int               run_len;
    logic [VAL_W-1:0] start_w;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // reset settings; the first two quads carry no first flag, so the sum runs on from zero
    send_quad(make_quad(8'h00, 64'h0706050403020100, 64'h0f0e0d0c0b0a0908, 1'b0, 1'b0));
    send_quad(make_quad(8'hff, '1, '1, 1'b0, 1'b0));
    send_quad(make_quad(8'he4, 64'h8899aabbccddeeff, 64'h0011223344556677, 1'b1, 1'b1));

    // zero-length mode, wrapping start; only the low bit of wide writes counts
    wait_drained();
    program_regs(32'hffff_ffff, 32'hffff_fffe, 32'hffff_ffff, 1'b1);
    send_quad(make_quad(8'h00, '1, '1, 1'b1, 1'b0));
    send_quad(make_quad(8'hff, '1, '1, 1'b0, 1'b0));
    send_quad(make_quad(8'he4, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b0));
    send_quad(make_quad(8'h1b, 64'h8000000180000001, 64'h7fffffff7fffffff, 1'b0, 1'b1));

    wait_drained();
    program_regs(32'h0000_0002, 32'h0000_0003, 32'h8000_0000, 1'b0);
    send_quad(make_quad(8'hff, '1, '1, 1'b1, 1'b0));
    send_quad(make_quad(8'h00, '0, '0, 1'b0, 1'b0));
    send_quad(make_quad(8'h55, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 1'b0));
    send_quad(make_quad(8'he4, 64'hfffffffe00000001, 64'h80000000ffffffff, 1'b0, 1'b1));

    // zigzag on zero-length integers must still add nothing
    wait_drained();
    program_regs(32'h0000_0001, 32'h0000_0001, 32'h0000_0000, 1'b1);
    send_quad(make_quad(8'h00, '1, '1, 1'b1, 1'b0));
    send_quad(make_quad(8'hff, '1, '1, 1'b0, 1'b0));
    send_quad(make_quad(8'haa, 64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 1'b1));
    send_quad(make_quad(8'h39, 64'h0000000100000002, 64'hffffffff00000003, 1'b1, 1'b1));

    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      idle_on <= (ph == PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 3))
        0:       start_w = '0;
        1:       start_w = '1;
        default: start_w = $urandom;
      endcase
      program_regs($urandom, $urandom, start_w, 1'($urandom_range(0, 1)));
      sent = 0;
      while (sent < PHASE_QUADS) begin
        run_len = $urandom_range(1, 12);
        for (int k = 0; k < run_len; k++) begin
          q.key_byte = 8'($urandom);
          q.window_low = pick_window();
          q.window_high = pick_window();
          q.first_quad = (k == 0);
          q.last_quad = (k == run_len - 1);
          // broken streams: stray or missing first and last flags
          if ($urandom_range(0, 9) == 0) begin
            q.first_quad = 1'($urandom);
            q.last_quad = 1'($urandom);
          end
          send_quad(q);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("stream_vbyte_delta_decoder_core regression: pass");
    end else begin
      $display("stream_vbyte_delta_decoder_core regression: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/svbd_pkg.sv
rtl/svbd_lane.sv
rtl/svbd_merge.sv
rtl/stream_vbyte_delta_decoder_core.sv
bench/stream_vbyte_delta_decoder_core_chk.sv
bench/stream_vbyte_delta_decoder_core_tb.sv
